### rtl/core/pnrw_pkg.sv
// shared types and constants of the packet number receive window
`default_nettype none
package pnrw_pkg;

  localparam int MODE_W     = 2;
  localparam int PN_W       = 62;
  localparam int LG_W       = 63;
  localparam int TIME_W     = 32;
  localparam int SPAN_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int GOFF_W     = 13;
  localparam int WORD_W     = 64;
  localparam int WORD_LG    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 2;
  localparam int QAW        = 1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GAPS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_NEW         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OLD         = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BEYOND      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MARKED      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MARK_BEYOND = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT = 1'b1;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd64;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_MARK,
    OP_GAPS
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PN_W-1:0]   pn;
    logic [TIME_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

  typedef enum logic [4:0] {
    BK_INIT,
    BK_IDLE,
    BK_CHK_START,
    BK_CHK_RD,
    BK_CHK_EV,
    BK_M_START,
    BK_M_SET_RD,
    BK_M_SET_WR,
    BK_M_TEST,
    BK_M_FIN,
    BK_ADV_START,
    BK_ADV_CLR0,
    BK_CLR_RD,
    BK_CLR_WR,
    BK_ADV_DONE,
    BK_SCAN_RD,
    BK_SCAN_EV,
    BK_G_START,
    BK_G_S,
    BK_G_E,
    BK_G_PUSH,
    BK_G_END,
    BK_EMIT
  } bk_state_t;

endpackage
`default_nettype wire

### rtl/core/pnrw_if.sv
// request and result channel interfaces
`default_nettype none
interface pnrw_in_if import pnrw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PN_W-1:0]     pn;
  logic [TIME_W-1:0]   now_us;

  modport source (output valid, mode, pn, now_us, input ready);
  modport sink (input valid, mode, pn, now_us, output ready);
endinterface

interface pnrw_out_if import pnrw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    gap_valid;
  logic [GOFF_W-1:0]       gap_start;
  logic [GOFF_W-1:0]       gap_end;
  logic                    last;
  logic [PN_W-1:0]         window_base;
  logic signed [LG_W-1:0]  largest_seen;

  modport source (output valid, status, gap_valid, gap_start, gap_end, last,
                  window_base, largest_seen, input ready);
  modport sink (input valid, status, gap_valid, gap_start, gap_end, last,
                window_base, largest_seen, output ready);
endinterface
`default_nettype wire

### rtl/core/pnrw_front.sv
// front stage: takes requests and classifies the mode
`default_nettype none
module pnrw_front import pnrw_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         en_i,
  pnrw_in_if.sink     in_if,
  input  wire         q_full_i,
  output q_wr_t       wr_o
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  op_t   op;
  logic  take;

  always_comb begin
    case (in_if.mode)
      MODE_MARK: op = OP_MARK;
      MODE_GAPS: op = OP_GAPS;
      default:   op = OP_CHECK;
    endcase
  end

  assign in_if.ready = en_i && (!valid_r || !q_full_i);
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (valid_r && !q_full_i) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt       = 1'b1;
      item_nxt.op     = op;
      item_nxt.pn     = in_if.pn;
      item_nxt.now_us = in_if.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign wr_o.push = valid_r && !q_full_i;
  assign wr_o.item = item_r;

endmodule
`default_nettype wire

### rtl/core/pnrw_fifo.sv
// short request queue between front and back
`default_nettype none
module pnrw_fifo import pnrw_pkg::*; (
  input  wire    clk,
  input  wire    rst_n,
  input  q_wr_t  wr_i,
  input  wire    pop_i,
  output logic   full_o,
  output q_rd_t  rd_o
);

  item_t            ent_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o     = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_o.valid = (cnt_r != '0);
  assign rd_o.item  = ent_r[rp_r];
  assign do_push    = wr_i.push && !full_o;
  assign do_pop     = pop_i && rd_o.valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= wr_i.item;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pnrw_back.sv
// back end: bitmap memory, window state and the request sequencer
`default_nettype none
module pnrw_back import pnrw_pkg::*; #(
  parameter int WINDOW_BITS    = 4096,
  parameter int MAX_GAP_BLOCKS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire [TIME_W-1:0]   tl_i,
  input  wire [SPAN_W-1:0]   span_i,
  input  q_rd_t              q_i,
  output logic               pop_o,
  output logic               ready_o,
  pnrw_out_if.source         out_if
);

  localparam int W  = WINDOW_BITS;
  localparam int OW = $clog2(W + 1);
  localparam int XW = OW + 1;
  localparam int PW = $clog2(W);
  localparam int NW = (W + WORD_W - 1) / WORD_W;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW = $clog2(MAX_GAP_BLOCKS + 1);
  localparam int LW = WORD_LG + 1;
  localparam logic [XW-1:0] W_X = XW'(W);
  localparam logic [OW-1:0] W_O = OW'(W);

  bk_state_t st_r, st_nxt;
  bk_state_t scan_ret_r, scan_ret_nxt;
  bk_state_t adv_ret_r, adv_ret_nxt;
  bk_state_t emit_ret_r, emit_ret_nxt;

  logic [WORD_W-1:0] mem [NW];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  item_t                  it_r, it_nxt;
  logic [PN_W-1:0]        base_r, base_nxt;
  logic signed [LG_W-1:0] largest_r, largest_nxt;
  logic signed [LG_W-1:0] middle_r, middle_nxt;
  logic [PN_W-1:0]        smallest_r, smallest_nxt;
  logic [TIME_W-1:0]      ltime_r, ltime_nxt;
  logic [TIME_W-1:0]      mtime_r, mtime_nxt;
  logic [PW-1:0]          h_r, h_nxt;
  logic [OW-1:0]          cur_r, cur_nxt;
  logic [OW-1:0]          found_r, found_nxt;
  logic [OW-1:0]          clr_n_r, clr_n_nxt;
  logic [OW-1:0]          s_r, s_nxt;
  logic [WORD_LG-1:0]     bb_r, bb_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic                   want_r, want_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic [GOFF_W-1:0]      pgs_r, pgs_nxt, pge_r, pge_nxt;
  logic [PN_W-1:0]        adv_p_r, adv_p_nxt;

  logic [STATUS_W-1:0]    res_st_r, res_st_nxt;
  logic                   res_gv_r, res_gv_nxt;
  logic [GOFF_W-1:0]      res_gs_r, res_gs_nxt, res_ge_r, res_ge_nxt;
  logic                   res_last_r, res_last_nxt;

  logic                   ov_r, ov_nxt;
  logic [STATUS_W-1:0]    o_st_r;
  logic                   o_gv_r, o_last_r;
  logic [GOFF_W-1:0]      o_gs_r, o_ge_r;
  logic [PN_W-1:0]        o_base_r;
  logic signed [LG_W-1:0] o_lg_r;
  logic                   o_load;

  // ring addressing of the current logical offset
  logic [XW-1:0]      phys_sum, phys, rem_ring, rem_log, len_min, rem_clr;
  logic [WORD_LG-1:0] bb;
  logic [LW-1:0]      rem_word, len_full, len_clr, hi;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W:0]    ones_hi, ones_lo;
  logic [WORD_W-1:0]  mask, vec, hit;
  logic               hit_any;
  logic [WORD_LG-1:0] hit_idx;
  logic [OW-1:0]      found_val;

  // wide compares
  logic [63:0]        base64u;
  logic signed [63:0] base_s, lg_s, mid_s, pn_s, mid_clamp, span_top, bs_sum;
  logic [PN_W-1:0]    diff;
  logic               below, beyond, diff_zero, is_largest, cond_ok, mid_ge_base;
  logic               no_gap, stop_s, stop_e, cnt_full, cur_end, clr_done;
  logic               init_last, o_free;
  logic [TIME_W-1:0]  deadline;
  logic [63:0]        adv_d;
  logic [LG_W-1:0]    so;
  logic [XW-1:0]      hs;
  logic [LG_W-1:0]    bsum;

  assign phys_sum = XW'(h_r) + XW'(cur_r);
  assign phys     = (phys_sum >= W_X) ? phys_sum - W_X : phys_sum;
  assign bb       = phys[WORD_LG-1:0];
  assign rem_word = LW'(WORD_W) - LW'(bb);
  assign rem_ring = W_X - phys;
  assign rem_log  = W_X - XW'(cur_r);
  assign len_min  = (rem_ring < rem_log) ? rem_ring : rem_log;
  assign len_full = (len_min < XW'(rem_word)) ? LW'(len_min) : rem_word;
  assign rem_clr  = XW'(clr_n_r) - XW'(cur_r);
  assign len_clr  = (XW'(len_full) < rem_clr) ? len_full : LW'(rem_clr);
  assign rd_addr  = AW'(phys >> WORD_LG);

  assign hi      = LW'(bb_r) + len_r;
  assign ones_hi = ({{WORD_W{1'b0}}, 1'b1} << hi) - (WORD_W+1)'(1);
  assign ones_lo = ({{WORD_W{1'b0}}, 1'b1} << bb_r) - (WORD_W+1)'(1);
  assign mask    = ones_hi[WORD_W-1:0] & ~ones_lo[WORD_W-1:0];
  assign vec     = want_r ? rdata_r : ~rdata_r;
  assign hit     = vec & mask;
  assign hit_any = |hit;

  // lowest set bit
  always_comb begin
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = WORD_LG'(i);
    end
  end

  assign found_val = cur_r + OW'(hit_idx) - OW'(bb_r);

  assign base64u     = {2'b00, base_r};
  assign base_s      = $signed(base64u);
  assign lg_s        = $signed({largest_r[LG_W-1], largest_r});
  assign mid_s       = $signed({middle_r[LG_W-1], middle_r});
  assign pn_s        = $signed({2'b00, it_r.pn});
  assign below       = it_r.pn < base_r;
  assign diff        = it_r.pn - base_r;
  assign beyond      = diff >= PN_W'(W);
  assign diff_zero   = (diff == '0);
  assign is_largest  = (lg_s == pn_s);
  assign mid_clamp   = (mid_s < base_s) ? mid_s : base_s;
  assign span_top    = mid_clamp + $signed(64'(span_i));
  assign deadline    = mtime_r + tl_i;
  assign cond_ok     = (ltime_r < deadline) && (lg_s <= span_top);
  assign mid_ge_base = (mid_s >= base_s);
  assign no_gap      = (lg_s <= base_s);
  assign bs_sum      = $signed(base64u + 64'(found_r));
  assign stop_s      = (lg_s <= bs_sum);
  assign stop_e      = (lg_s <= (bs_sum - 64'sd1));
  assign cnt_full    = ((cnt_r + CW'(1)) == CW'(MAX_GAP_BLOCKS));
  assign cur_end     = (cur_r >= W_O);
  assign clr_done    = (cur_r >= clr_n_r);
  assign init_last   = (addr_r == AW'(NW - 1));
  assign o_free      = !ov_r || out_if.ready;
  assign adv_d       = {2'b00, adv_p_r} + 64'd1 - base64u;
  assign so          = {1'b0, smallest_r} + LG_W'(1);
  assign hs          = XW'(h_r) + XW'(clr_n_r);
  assign bsum        = {1'b0, base_r} + LG_W'(clr_n_r);

  assign pop_o   = (st_r == BK_IDLE) && q_i.valid;
  assign ready_o = (st_r != BK_INIT);
  assign o_load  = (st_r == BK_EMIT) && o_free;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_INIT:      st_nxt = init_last ? BK_IDLE : BK_INIT;
      BK_IDLE: begin
        if (q_i.valid) begin
          case (q_i.item.op)
            OP_MARK: st_nxt = BK_M_START;
            OP_GAPS: st_nxt = BK_G_START;
            default: st_nxt = BK_CHK_START;
          endcase
        end
      end
      BK_CHK_START: st_nxt = (below || beyond) ? BK_EMIT : BK_CHK_RD;
      BK_CHK_RD:    st_nxt = BK_CHK_EV;
      BK_CHK_EV:    st_nxt = BK_EMIT;
      BK_M_START: begin
        if (below || beyond) st_nxt = BK_EMIT;
        else if (diff_zero)  st_nxt = BK_ADV_START;
        else                 st_nxt = BK_M_SET_RD;
      end
      BK_M_SET_RD:  st_nxt = BK_M_SET_WR;
      BK_M_SET_WR:  st_nxt = BK_M_TEST;
      BK_M_TEST: begin
        if (!is_largest || cond_ok) st_nxt = BK_EMIT;
        else if (mid_ge_base)       st_nxt = BK_ADV_START;
        else                        st_nxt = BK_M_FIN;
      end
      BK_M_FIN:     st_nxt = BK_EMIT;
      BK_ADV_START: st_nxt = BK_SCAN_RD;
      BK_ADV_CLR0:  st_nxt = BK_CLR_RD;
      BK_CLR_RD:    st_nxt = clr_done ? BK_ADV_DONE : BK_CLR_WR;
      BK_CLR_WR:    st_nxt = BK_CLR_RD;
      BK_ADV_DONE:  st_nxt = adv_ret_r;
      BK_SCAN_RD:   st_nxt = cur_end ? scan_ret_r : BK_SCAN_EV;
      BK_SCAN_EV:   st_nxt = hit_any ? scan_ret_r : BK_SCAN_RD;
      BK_G_START:   st_nxt = no_gap ? BK_EMIT : BK_SCAN_RD;
      BK_G_S:       st_nxt = stop_s ? BK_G_END : BK_SCAN_RD;
      BK_G_E: begin
        if (stop_e)      st_nxt = BK_G_END;
        else if (pend_r) st_nxt = BK_EMIT;
        else             st_nxt = BK_G_PUSH;
      end
      BK_G_PUSH:    st_nxt = cnt_full ? BK_G_END : BK_SCAN_RD;
      BK_G_END:     st_nxt = BK_EMIT;
      BK_EMIT:      st_nxt = o_free ? emit_ret_r : BK_EMIT;
      default:      st_nxt = BK_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    it_nxt       = it_r;
    base_nxt     = base_r;
    largest_nxt  = largest_r;
    middle_nxt   = middle_r;
    smallest_nxt = smallest_r;
    ltime_nxt    = ltime_r;
    mtime_nxt    = mtime_r;
    h_nxt        = h_r;
    cur_nxt      = cur_r;
    found_nxt    = found_r;
    clr_n_nxt    = clr_n_r;
    s_nxt        = s_r;
    bb_nxt       = bb_r;
    len_nxt      = len_r;
    addr_nxt     = addr_r;
    want_nxt     = want_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pgs_nxt      = pgs_r;
    pge_nxt      = pge_r;
    adv_p_nxt    = adv_p_r;
    scan_ret_nxt = scan_ret_r;
    adv_ret_nxt  = adv_ret_r;
    emit_ret_nxt = emit_ret_r;
    res_st_nxt   = res_st_r;
    res_gv_nxt   = res_gv_r;
    res_gs_nxt   = res_gs_r;
    res_ge_nxt   = res_ge_r;
    res_last_nxt = res_last_r;
    mem_we       = 1'b0;
    mem_wa       = addr_r;
    mem_wd       = '0;
    ov_nxt       = ov_r && !out_if.ready;

    case (st_r)
      BK_INIT: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      BK_IDLE: begin
        it_nxt       = q_i.item;
        emit_ret_nxt = BK_IDLE;
        res_gv_nxt   = 1'b0;
        res_gs_nxt   = '0;
        res_ge_nxt   = '0;
        res_last_nxt = 1'b1;
      end
      BK_CHK_START: begin
        res_st_nxt = below ? STAT_OLD : STAT_BEYOND;
        cur_nxt    = OW'(diff);
      end
      BK_CHK_RD, BK_M_SET_RD: begin
        bb_nxt   = bb;
        addr_nxt = rd_addr;
      end
      BK_CHK_EV: res_st_nxt = rdata_r[bb_r] ? STAT_OLD : STAT_NEW;
      BK_M_START: begin
        res_st_nxt = below ? STAT_OLD : STAT_MARK_BEYOND;
        if (!(below || beyond)) begin
          if (lg_s < pn_s) begin
            largest_nxt = {1'b0, it_r.pn};
            ltime_nxt   = it_r.now_us;
          end
          if (smallest_r > it_r.pn) begin
            smallest_nxt = it_r.pn;
            middle_nxt   = {1'b0, it_r.pn};
          end
          adv_p_nxt   = it_r.pn;
          adv_ret_nxt = BK_M_TEST;
          cur_nxt     = OW'(diff);
        end
      end
      BK_M_SET_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata_r | (WORD_W'(1) << bb_r);
      end
      BK_M_TEST: begin
        res_st_nxt  = STAT_MARKED;
        adv_p_nxt   = middle_r[PN_W-1:0];
        adv_ret_nxt = BK_M_FIN;
      end
      BK_M_FIN: begin
        smallest_nxt = middle_r[PN_W-1:0];
        middle_nxt   = largest_r;
        mtime_nxt    = ltime_r;
        res_st_nxt   = STAT_MARKED;
      end
      BK_ADV_START: begin
        cur_nxt      = (adv_d >= 64'(W)) ? W_O : OW'(adv_d);
        want_nxt     = 1'b0;
        scan_ret_nxt = BK_ADV_CLR0;
      end
      BK_ADV_CLR0: begin
        clr_n_nxt = found_r;
        cur_nxt   = '0;
      end
      BK_CLR_RD: begin
        bb_nxt   = bb;
        len_nxt  = len_clr;
        addr_nxt = rd_addr;
      end
      BK_CLR_WR: begin
        mem_we  = 1'b1;
        mem_wd  = rdata_r & ~mask;
        cur_nxt = cur_r + OW'(len_r);
      end
      BK_ADV_DONE: begin
        h_nxt    = PW'((hs >= W_X) ? hs - W_X : hs);
        base_nxt = bsum[LG_W-1] ? {PN_W{1'b1}} : bsum[PN_W-1:0];
      end
      BK_SCAN_RD: begin
        bb_nxt   = bb;
        len_nxt  = len_full;
        addr_nxt = rd_addr;
        if (cur_end) found_nxt = W_O;
      end
      BK_SCAN_EV: begin
        if (hit_any) found_nxt = found_val;
        else         cur_nxt   = cur_r + OW'(len_r);
      end
      BK_G_START: begin
        res_st_nxt = STAT_NEW;
        cnt_nxt    = '0;
        pend_nxt   = 1'b0;
        if (base_r == '0) begin
          cur_nxt = (so >= LG_W'(W)) ? W_O : OW'(so);
        end else begin
          cur_nxt = '0;
        end
        want_nxt     = 1'b0;
        scan_ret_nxt = BK_G_S;
      end
      BK_G_S: begin
        s_nxt        = found_r;
        cur_nxt      = found_r;
        want_nxt     = 1'b1;
        scan_ret_nxt = BK_G_E;
      end
      BK_G_E: begin
        res_gv_nxt   = 1'b1;
        res_gs_nxt   = pgs_r;
        res_ge_nxt   = pge_r;
        res_last_nxt = 1'b0;
        emit_ret_nxt = BK_G_PUSH;
      end
      BK_G_PUSH: begin
        pend_nxt     = 1'b1;
        pgs_nxt      = GOFF_W'(XW'(s_r) + XW'(1));
        pge_nxt      = GOFF_W'(found_r);
        cnt_nxt      = cnt_r + CW'(1);
        cur_nxt      = found_r;
        want_nxt     = 1'b0;
        scan_ret_nxt = BK_G_S;
      end
      BK_G_END: begin
        res_gv_nxt   = pend_r;
        res_gs_nxt   = pend_r ? pgs_r : '0;
        res_ge_nxt   = pend_r ? pge_r : '0;
        res_last_nxt = 1'b1;
        emit_ret_nxt = BK_IDLE;
      end
      BK_EMIT: begin
        if (o_free) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= BK_INIT;
      scan_ret_r <= BK_IDLE;
      adv_ret_r  <= BK_IDLE;
      emit_ret_r <= BK_IDLE;
      base_r     <= '0;
      largest_r  <= '1;
      middle_r   <= '1;
      smallest_r <= '1;
      ltime_r    <= '0;
      mtime_r    <= '0;
      h_r        <= '0;
      addr_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      scan_ret_r <= scan_ret_nxt;
      adv_ret_r  <= adv_ret_nxt;
      emit_ret_r <= emit_ret_nxt;
      base_r     <= base_nxt;
      largest_r  <= largest_nxt;
      middle_r   <= middle_nxt;
      smallest_r <= smallest_nxt;
      ltime_r    <= ltime_nxt;
      mtime_r    <= mtime_nxt;
      h_r        <= h_nxt;
      addr_r     <= addr_nxt;
      ov_r       <= ov_nxt;
    end
    it_r       <= it_nxt;
    cur_r      <= cur_nxt;
    found_r    <= found_nxt;
    clr_n_r    <= clr_n_nxt;
    s_r        <= s_nxt;
    bb_r       <= bb_nxt;
    len_r      <= len_nxt;
    want_r     <= want_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    pgs_r      <= pgs_nxt;
    pge_r      <= pge_nxt;
    adv_p_r    <= adv_p_nxt;
    res_st_r   <= res_st_nxt;
    res_gv_r   <= res_gv_nxt;
    res_gs_r   <= res_gs_nxt;
    res_ge_r   <= res_ge_nxt;
    res_last_r <= res_last_nxt;
    if (o_load) begin
      o_st_r   <= res_st_r;
      o_gv_r   <= res_gv_r;
      o_gs_r   <= res_gs_r;
      o_ge_r   <= res_ge_r;
      o_last_r <= res_last_r;
      o_base_r <= base_r;
      o_lg_r   <= largest_r;
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.status       = o_st_r;
  assign out_if.gap_valid    = o_gv_r;
  assign out_if.gap_start    = o_gs_r;
  assign out_if.gap_end      = o_ge_r;
  assign out_if.last         = o_last_r;
  assign out_if.window_base  = o_base_r;
  assign out_if.largest_seen = o_lg_r;

  a_base_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> base_r >= $past(base_r))
    else $error("window base moved backward");

  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(h_r) < W_X)
    else $error("ring head outside window");

  a_gap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_gv_r |-> o_gs_r <= o_ge_r && o_gs_r != '0)
    else $error("gap block with start past end");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_INIT |-> !ov_r && !pop_o)
    else $error("activity during bitmap clearing");

endmodule
`default_nettype wire

### rtl/core/packet_number_receive_window.sv
// top level of the packet number receive window
//
//  channel   dir  handshake            payload
//  in_if     in   valid/ready          mode, pn, now_us
//  out_if    out  valid/ready          status, gap_valid, gap_start, gap_end,
//                                      last, window_base, largest_seen
//  cfg_*     in   cfg_we (no stall)    cfg_idx, cfg_data
//
// a check reads the bitmap word of its packet number; a mark that leaves the base
// alone reads, sets and writes back that word; base advance: a zero search that
// reads and tests each 64-bit word touched, then a clear that rewrites each word
// a gap report scans the bitmap word by word, pausing to emit each found block
// after reset a clearing pass writes one word a cycle, during which no request
// is taken; config writes are taken as ever
// the front and a 2-entry queue keep taking requests while a result stalls
`default_nettype none
module packet_number_receive_window import pnrw_pkg::*; #(
  parameter int WINDOW_BITS    = 4096,
  parameter int MAX_GAP_BLOCKS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  pnrw_in_if.sink               in_if,
  pnrw_out_if.source            out_if,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_idx,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [TIME_W-1:0] time_limit_r, time_limit_nxt;
  logic [SPAN_W-1:0] span_limit_r, span_limit_nxt;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;
  logic  back_ready;

  always_comb begin
    time_limit_nxt = time_limit_r;
    span_limit_nxt = span_limit_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_TIME_LIMIT: time_limit_nxt = cfg_data[TIME_W-1:0];
        CFG_SPAN_LIMIT: span_limit_nxt = cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_limit_r <= '0;
      span_limit_r <= SPAN_RESET;
    end else begin
      time_limit_r <= time_limit_nxt;
      span_limit_r <= span_limit_nxt;
    end
  end

  // front: request register and mode decode, held off during clearing
  pnrw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (back_ready),
    .in_if    (in_if),
    .q_full_i (q_full),
    .wr_o     (q_wr)
  );

  // decoupling queue
  pnrw_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .full_o (q_full),
    .rd_o   (q_rd)
  );

  // back: bitmap, window state, scans and result register
  pnrw_back #(
    .WINDOW_BITS    (WINDOW_BITS),
    .MAX_GAP_BLOCKS (MAX_GAP_BLOCKS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .tl_i    (time_limit_r),
    .span_i  (span_limit_r),
    .q_i     (q_rd),
    .pop_o   (q_pop),
    .ready_o (back_ready),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire
